@@ hdl/dscprm_pkg.sv @@
// Shared types and constants for the DSCP remark and IPv4 checksum block.
package dscprm_pkg;

	localparam int WORD_W    = 16;
	localparam int DSCP_W    = 6;
	localparam int PRIO_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int TGT_W     = 6;

	// Word positions in the frame: version/IHL + TOS, header checksum.
	localparam int VERHL_WORD      = 7;
	localparam int CSUM_WORD       = 12;
	localparam int MIN_FRAME_WORDS = 17;

	localparam logic [DSCP_W-1:0] DSCP_P1_RST = 6'd10;
	localparam logic [DSCP_W-1:0] DSCP_P2_RST = 6'd34;
	localparam logic [DSCP_W-1:0] DSCP_P3_RST = 6'd46;

	localparam logic [PRIO_W-1:0] PRIO_ONE   = 3'd1;
	localparam logic [PRIO_W-1:0] PRIO_TWO   = 3'd2;
	localparam logic [PRIO_W-1:0] PRIO_THREE = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DSCP_P1 = 2'd0,
		CFG_DSCP_P2 = 2'd1,
		CFG_DSCP_P3 = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_BUF,
		ST_PASS,
		ST_BURST_RD,
		ST_BURST_LD
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              add;
		logic [WORD_W-1:0] word;
	} csum_ctl_t;

endpackage

@@ hdl/dscprm_if.sv @@
// Channel interfaces: frame input, remarked output and configuration writes.
interface dscprm_frame_if import dscprm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] frame_word;
	logic              frame_last;
	logic              single_byte_tail;
	logic [PRIO_W-1:0] packet_priority;

	modport source (output valid, frame_word, frame_last, single_byte_tail, packet_priority,
		input ready);
	modport sink (input valid, frame_word, frame_last, single_byte_tail, packet_priority,
		output ready);
endinterface

interface dscprm_result_if import dscprm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] out_word;
	logic              out_last;
	logic              out_single_byte_tail;

	modport source (output valid, out_word, out_last, out_single_byte_tail, input ready);
	modport sink (input valid, out_word, out_last, out_single_byte_tail, output ready);
endinterface

interface dscprm_cfg_if import dscprm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DSCP_W-1:0]    wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

@@ hdl/dscp_remark_ip_checksum.sv @@
// DSCP remark with IPv4 header checksum rebuild: top level and control.
//
// Frames arrive as 16-bit big-endian words. The first words of each frame
// (at least 17, or 7 + 2*IHL when that is larger) are written into a header
// store of HEADER_BUFFER_WORDS entries, one word per cycle, while the
// checksum over the IP header words builds up alongside. When the header is
// complete the TOS byte becomes DSCP<<2 (DSCP picked by the priority sampled
// on the first word: registers 0..2 for priorities 1..3, zero otherwise) and
// the checksum word is replaced; the store is then read back as a burst
// with the input held off, each word in two steps, a memory read and a
// load of the output register. The rest of the frame passes through the
// output register at one word per cycle while the output is not stalled.
// Frames that end before the header is complete, or end on it with a
// single-byte tail, come out unchanged; a header that does not fit the
// store goes out unchanged when the store fills. DSCP registers are
// sampled during the burst, so write them only while the block is idle.
module dscp_remark_ip_checksum import dscprm_pkg::*; #(
	parameter int HEADER_BUFFER_WORDS = 37
) (
	input  logic        clk,
	input  logic        arst_n,
	dscprm_frame_if.sink    frame,
	dscprm_result_if.source remarked,
	dscprm_cfg_if.sink      cfg
);

	localparam int DEPTH = HEADER_BUFFER_WORDS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [CW-1:0]    VERHL_IDX = CW'(VERHL_WORD);
	localparam logic [CW-1:0]    CSUM_IDX  = CW'(CSUM_WORD);
	localparam logic [CW-1:0]    DEPTH_CNT = CW'(DEPTH);
	localparam logic [TGT_W-1:0] MIN_TGT   = TGT_W'(MIN_FRAME_WORDS);
	localparam logic [TGT_W-1:0] VERHL_TGT = TGT_W'(VERHL_WORD);
	localparam logic [TGT_W-1:0] DEPTH_TGT = TGT_W'(DEPTH);

	state_t state_q, state_n;

	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     len_q;
	logic [PRIO_W-1:0] prio_q;
	logic [7:0]        verihl_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              rewrite_q;
	logic              blast_q;
	logic              btail_q;
	logic [DSCP_W-1:0] dscp1_q;
	logic [DSCP_W-1:0] dscp2_q;
	logic [DSCP_W-1:0] dscp3_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_last_q;
	logic              out_tail_q;

	logic              in_acc;
	logic              tail_in;
	logic              out_free;
	logic [CW-1:0]     cnt_n;
	logic [TGT_W-1:0]  need;
	logic [TGT_W-1:0]  new_tgt;
	logic [TGT_W-1:0]  tgt;
	logic [TGT_W-1:0]  hdr_end;
	logic              emit;
	logic              rewrite_n;
	logic              mem_re;
	logic              load_pass;
	logic              load_burst;
	logic              burst_final;
	logic [DSCP_W-1:0] dscp_sel;
	logic [WORD_W-1:0] tos_word;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] burst_word;
	logic [WORD_W-1:0] csum;
	csum_ctl_t         csum_ctl;

	// ---------------------------------------------------------------- config
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dscp1_q <= DSCP_P1_RST;
			dscp2_q <= DSCP_P2_RST;
			dscp3_q <= DSCP_P3_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DSCP_P1: dscp1_q <= cfg.wdata;
				CFG_DSCP_P2: dscp2_q <= cfg.wdata;
				CFG_DSCP_P3: dscp3_q <= cfg.wdata;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	always_comb begin
		unique case (prio_q)
			PRIO_ONE:   dscp_sel = dscp1_q;
			PRIO_TWO:   dscp_sel = dscp2_q;
			PRIO_THREE: dscp_sel = dscp3_q;
			default:    dscp_sel = '0;
		endcase
	end

	// New TOS byte clears ECN; the version/IHL byte stays as received.
	assign tos_word = {verihl_q, dscp_sel, 2'b00};

	// ------------------------------------------------------------ datapath
	assign in_acc   = frame.valid && frame.ready;
	assign tail_in  = frame.frame_last && frame.single_byte_tail;
	assign out_free = !out_valid_q || remarked.ready;
	assign cnt_n    = cnt_q + 1'b1;

	// Buffer target from the IHL nibble of word 7, never below 17 words.
	assign need    = VERHL_TGT + {1'b0, frame.frame_word[11:8], 1'b0};
	assign new_tgt = (need < MIN_TGT) ? MIN_TGT : need;
	always_comb begin
		if (cnt_q == VERHL_IDX) begin
			tgt = new_tgt;
		end else if (cnt_q > VERHL_IDX) begin
			tgt = tgt_q;
		end else begin
			tgt = MIN_TGT;
		end
	end

	// Words 8 up to the end of the IP header join the sum as they arrive;
	// skip the checksum word itself.
	assign hdr_end = VERHL_TGT + {1'b0, verihl_q[3:0], 1'b0};
	always_comb begin
		csum_ctl.clear = (state_q == ST_BUF) && in_acc && (cnt_q == '0);
		csum_ctl.add   = (state_q == ST_BUF) && in_acc && (cnt_q > VERHL_IDX)
			&& (cnt_q != CSUM_IDX) && (TGT_W'(cnt_q) < hdr_end);
		csum_ctl.word  = frame.frame_word;
	end

	dscprm_csum u_csum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (csum_ctl),
		.tos_word (tos_word),
		.tos_incl (verihl_q[3:0] != 4'd0),
		.csum     (csum)
	);

	dscprm_hdr_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    ((state_q == ST_BUF) && in_acc),
		.waddr (cnt_q[AW-1:0]),
		.wdata (frame.frame_word),
		.re    (mem_re),
		.raddr (k_q[AW-1:0]),
		.rdata (rd_data)
	);

	assign burst_final = ((k_q + 1'b1) == len_q);

	always_comb begin
		burst_word = rd_data;
		if (rewrite_q && (k_q == VERHL_IDX)) begin
			burst_word = {rd_data[15:8], dscp_sel, 2'b00};
		end else if (rewrite_q && (k_q == CSUM_IDX)) begin
			burst_word = csum;
		end
	end

	// --------------------------------------------------------------- control
	always_comb begin
		state_n     = state_q;
		frame.ready = 1'b0;
		emit        = 1'b0;
		rewrite_n   = 1'b0;
		mem_re      = 1'b0;
		load_pass   = 1'b0;
		load_burst  = 1'b0;
		unique case (state_q)
			ST_BUF: begin
				frame.ready = 1'b1;
				if (in_acc) begin
					if (tgt > DEPTH_TGT) begin
						// Header cannot fit: flush unchanged when full or at frame end.
						emit = frame.frame_last || (cnt_n == DEPTH_CNT);
					end else if (TGT_W'(cnt_n) < tgt) begin
						emit = frame.frame_last;
					end else begin
						emit      = 1'b1;
						rewrite_n = !tail_in;
					end
				end
				if (emit) begin
					state_n = ST_BURST_RD;
				end
			end
			ST_PASS: begin
				frame.ready = out_free;
				if (in_acc) begin
					load_pass = 1'b1;
					if (frame.frame_last) begin
						state_n = ST_BUF;
					end
				end
			end
			ST_BURST_RD: begin
				mem_re  = 1'b1;
				state_n = ST_BURST_LD;
			end
			ST_BURST_LD: begin
				if (out_free) begin
					load_burst = 1'b1;
					if (burst_final) begin
						state_n = blast_q ? ST_BUF : ST_PASS;
					end else begin
						state_n = ST_BURST_RD;
					end
				end
			end
			default: state_n = ST_BUF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUF;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			k_q       <= '0;
			len_q     <= '0;
			prio_q    <= '0;
			verihl_q  <= '0;
			tgt_q     <= '0;
			rewrite_q <= 1'b0;
			blast_q   <= 1'b0;
			btail_q   <= 1'b0;
		end else begin
			if ((state_q == ST_BUF) && in_acc) begin
				cnt_q <= emit ? '0 : cnt_n;
				if (cnt_q == '0) begin
					prio_q <= frame.packet_priority;
				end
				if (cnt_q == VERHL_IDX) begin
					verihl_q <= frame.frame_word[15:8];
					tgt_q    <= new_tgt;
				end
			end
			if (emit) begin
				k_q       <= '0;
				len_q     <= cnt_n;
				rewrite_q <= rewrite_n;
				blast_q   <= frame.frame_last;
				btail_q   <= tail_in;
			end else if (load_burst) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pass || load_burst) begin
			out_valid_q <= 1'b1;
		end else if (remarked.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pass) begin
			out_word_q <= frame.frame_word;
			out_last_q <= frame.frame_last;
			out_tail_q <= tail_in;
		end else if (load_burst) begin
			out_word_q <= burst_word;
			out_last_q <= blast_q && burst_final;
			out_tail_q <= btail_q && burst_final;
		end
	end

	assign remarked.valid                = out_valid_q;
	assign remarked.out_word             = out_word_q;
	assign remarked.out_last             = out_last_q;
	assign remarked.out_single_byte_tail = out_tail_q;

	// ------------------------------------------------------------ assertions
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BURST_RD || state_q == ST_BURST_LD) |-> !frame.ready)
		else $error("input accepted during header burst");

	a_burst_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BURST_RD || state_q == ST_BURST_LD) |-> (k_q < len_q))
		else $error("burst index past buffered length");

	a_store_not_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUF) |-> (cnt_q < DEPTH_CNT))
		else $error("header store overrun");

	a_last_burst_word_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(load_burst && burst_final && blast_q) |=> (state_q == ST_BUF && cnt_q == '0))
		else $error("frame end in burst did not return to buffering");

endmodule

@@ hdl/dscprm_hdr_mem.sv @@
// Header word store: one write port, one registered read port.
module dscprm_hdr_mem import dscprm_pkg::*; #(
	parameter int DEPTH = 37
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WORD_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WORD_W-1:0]        rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the last read word until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/dscprm_csum.sv @@
// Ones-complement accumulator for the IPv4 header checksum.
module dscprm_csum import dscprm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  csum_ctl_t         ctl,
	input  logic [WORD_W-1:0] tos_word,
	input  logic              tos_incl,
	output logic [WORD_W-1:0] csum
);

	logic [WORD_W-1:0] acc_q;
	logic [WORD_W:0]   add_sum;
	logic [WORD_W-1:0] add_fold;
	logic [WORD_W:0]   fin_sum;
	logic [WORD_W-1:0] fin_fold;

	// Fold the carry back in; the result cannot carry again.
	assign add_sum  = {1'b0, acc_q} + {1'b0, ctl.word};
	assign add_fold = add_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, add_sum[WORD_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= add_fold;
		end
	end

	// The rewritten TOS word joins combinationally, once the DSCP is settled.
	assign fin_sum  = {1'b0, acc_q} + {1'b0, tos_word};
	assign fin_fold = fin_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fin_sum[WORD_W]};
	assign csum     = tos_incl ? ~fin_fold : ~acc_q;

endmodule

@@ dv/dscprm_remark_check.sv @@
// Output checker for the DSCP remark block: predicts remarked frame words and compares them.
module dscprm_remark_check import dscprm_pkg::*; #(
	parameter int HDR_WORDS = 37
) (
	input  logic     clk,
	input  logic     arst_n,
	dscprm_frame_if  frame,
	dscprm_result_if remarked,
	dscprm_cfg_if    cfg,
	output int       error_count,
	output int       open_words,
	output int       checked_words
);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
		logic              tail;
	} remarked_word_t;

	remarked_word_t    expected_words[$];
	remarked_word_t    oldest;

	// Shadow of the block: header store, frame position and DSCP registers.
	logic [WORD_W-1:0] hdr_store [HDR_WORDS];
	int                hdr_count;
	int                hdr_target;
	logic [PRIO_W-1:0] frame_prio;
	bit                passing;
	logic [DSCP_W-1:0] dscp_p1, dscp_p2, dscp_p3;

	function automatic logic [DSCP_W-1:0] dscp_for(input logic [PRIO_W-1:0] prio);
		case (prio)
			PRIO_ONE:   return dscp_p1;
			PRIO_TWO:   return dscp_p2;
			PRIO_THREE: return dscp_p3;
			default:    return '0;
		endcase
	endfunction

	// New TOS, then ones-complement sum over IHL*2 words with the checksum zeroed.
	task automatic rewrite_ip_header();
		int sum_words;
		int acc;
		sum_words = 2 * int'(hdr_store[VERHL_WORD][11:8]);
		hdr_store[VERHL_WORD][7:0] = {dscp_for(frame_prio), 2'b00};
		hdr_store[CSUM_WORD] = '0;
		acc = 0;
		for (int i = 0; i < sum_words; i++) begin
			if (VERHL_WORD + i < HDR_WORDS) begin
				acc += hdr_store[VERHL_WORD + i];
				if (acc > 'hFFFF)
					acc = (acc & 'hFFFF) + 1;
			end
		end
		hdr_store[CSUM_WORD] = ~acc[15:0];
	endtask

	task automatic release_header(input int count, input bit last, input bit tail);
		bit fin;
		for (int k = 0; k < count && k < HDR_WORDS; k++) begin
			fin = last && (k + 1 == count);
			expected_words.push_back('{hdr_store[k], fin, fin && tail});
		end
	endtask

	task automatic predict_remarked_words(input logic [WORD_W-1:0] word, input logic last,
		input logic tail_in, input logic [PRIO_W-1:0] prio);
		bit tail;
		int need;
		int target;
		tail = last && tail_in;
		if (passing) begin
			expected_words.push_back('{word, last, tail});
			if (last) begin
				passing = 0;
				hdr_count = 0;
			end
			return;
		end
		if (hdr_count == 0)
			frame_prio = prio;
		if (hdr_count < HDR_WORDS)
			hdr_store[hdr_count] = word;
		hdr_count++;
		if (hdr_count == VERHL_WORD + 1) begin
			need = VERHL_WORD + 2 * int'(word[11:8]);
			hdr_target = (need < MIN_FRAME_WORDS) ? MIN_FRAME_WORDS : need;
		end
		target = (hdr_count > VERHL_WORD) ? hdr_target : MIN_FRAME_WORDS;
		if (target > HDR_WORDS) begin
			if (last || hdr_count >= HDR_WORDS) begin
				release_header(hdr_count, last, tail);
				hdr_count = 0;
				passing = !last;
			end
			return;
		end
		if (hdr_count < target) begin
			if (last) begin
				release_header(hdr_count, 1'b1, tail);
				hdr_count = 0;
			end
			return;
		end
		if (!(last && tail))
			rewrite_ip_header();
		release_header(hdr_count, last, tail);
		hdr_count = 0;
		passing = !last;
	endtask

	task automatic report(input string what, input int exp_val, input int got_val);
		error_count++;
		if (error_count <= 25)
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, got_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			hdr_count = 0;
			hdr_target = MIN_FRAME_WORDS;
			frame_prio = '0;
			passing = 0;
			dscp_p1 = DSCP_P1_RST;
			dscp_p2 = DSCP_P2_RST;
			dscp_p3 = DSCP_P3_RST;
			error_count = 0;
			checked_words = 0;
			open_words <= 0;
		end else begin
			// Compare first: an output word never stems from an input taken at this edge.
			if (remarked.valid && remarked.ready) begin
				if (expected_words.size() == 0) begin
					error_count++;
					if (error_count <= 25)
						$display("%0t: output word %h with none expected", $time,
							remarked.out_word);
				end else begin
					oldest = expected_words.pop_front();
					checked_words++;
					if (oldest.word !== remarked.out_word)
						report("out_word", oldest.word, remarked.out_word);
					if (oldest.last !== remarked.out_last)
						report("out_last", oldest.last, remarked.out_last);
					if (oldest.tail !== remarked.out_single_byte_tail)
						report("out_single_byte_tail", oldest.tail,
							remarked.out_single_byte_tail);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DSCP_P1: dscp_p1 = cfg.wdata;
					CFG_DSCP_P2: dscp_p2 = cfg.wdata;
					CFG_DSCP_P3: dscp_p3 = cfg.wdata;
					default: ;
				endcase
			end
			if (frame.valid && frame.ready)
				predict_remarked_words(frame.frame_word, frame.frame_last,
					frame.single_byte_tail, frame.packet_priority);
			open_words <= expected_words.size();
		end
	end

endmodule

@@ dv/tb.sv @@
// Top of the DSCP remark testbench: clock, reset, frame and register stimulus, verdict.
module tb;
	import dscprm_pkg::*;

	localparam int HDR_WORDS = 37;

	// How a frame body is filled; noise leaves the version/IHL word random too.
	typedef enum int {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS,
		FILL_NOISE
	} fill_t;

	// Output back-pressure styles the sink cycles through.
	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_SLOW,
		SINK_PERIODIC
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int remark_errors;
	int open_words;
	int checked_words;

	int burst_left;
	int words_sent;
	int frames_sent;
	int settings_used;

	sink_mode_t sink_mode;
	int         mode_left;
	int         sink_phase;

	dscprm_frame_if  frame_ch();
	dscprm_result_if remarked_ch();
	dscprm_cfg_if    cfg_ch();

	dscp_remark_ip_checksum #(
		.HEADER_BUFFER_WORDS(HDR_WORDS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame_ch),
		.remarked (remarked_ch),
		.cfg      (cfg_ch)
	);

	dscprm_remark_check #(
		.HDR_WORDS(HDR_WORDS)
	) u_remark_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame         (frame_ch),
		.remarked      (remarked_ch),
		.cfg           (cfg_ch),
		.error_count   (remark_errors),
		.open_words    (open_words),
		.checked_words (checked_words)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sink: hold one back-pressure style for a random stretch, then switch.
	// The open style gives long runs with no stalls at all.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 200);
		end
		mode_left--;
		sink_phase++;
		case (sink_mode)
			SINK_OPEN:     remarked_ch.ready <= 1'b1;
			SINK_RANDOM:   remarked_ch.ready <= 1'($urandom_range(0, 1));
			SINK_SLOW:     remarked_ch.ready <= ($urandom_range(0, 3) == 0);
			SINK_PERIODIC: remarked_ch.ready <= (sink_phase % 5) < 3;
			default:       remarked_ch.ready <= 1'b1;
		endcase
	end

	// Hand one frame word to the block. Between bursts drop valid for a random
	// gap, sometimes none; within a burst keep valid high from word to word.
	task automatic push_word(input logic [WORD_W-1:0] w, input logic last, input logic tail,
		input logic [PRIO_W-1:0] prio);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				frame_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		frame_ch.valid            <= 1'b1;
		frame_ch.frame_word       <= w;
		frame_ch.frame_last       <= last;
		frame_ch.single_byte_tail <= tail;
		frame_ch.packet_priority  <= prio;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Build and send one frame. Priority matters on the first word only, so
	// randomize it on the others; the tail flag is random on non-final words.
	task automatic send_frame(input int len, input logic [3:0] ihl,
		input logic [PRIO_W-1:0] prio, input logic end_tail, input fill_t fill);
		logic [WORD_W-1:0] w;
		logic              fin;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ONES:  w = '1;
				FILL_ZEROS: w = '0;
				default:    w = WORD_W'($urandom_range(0, 16'hFFFF));
			endcase
			if (i == VERHL_WORD && fill != FILL_NOISE) begin
				w[11:8] = ihl;
				if (fill == FILL_RANDOM)
					w[15:12] = 4'h4;
			end
			fin = (i == len - 1);
			push_word(w, fin, fin ? end_tail : 1'($urandom_range(0, 1)),
				(i == 0) ? prio : PRIO_W'($urandom_range(0, 7)));
		end
		frames_sent++;
	endtask

	// Mostly well-formed frames with random, all-ones or all-zeros content;
	// the rest are frames that stop short, end on the header with a one-byte
	// tail, carry an IHL under five, or are pure noise.
	task automatic random_frame();
		int                kind;
		int                tgt;
		logic [3:0]        ihl;
		logic [PRIO_W-1:0] prio;
		logic              tail;
		kind = $urandom_range(0, 9);
		ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
		tgt  = 7 + 2 * ihl;
		if (tgt < MIN_FRAME_WORDS)
			tgt = MIN_FRAME_WORDS;
		prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(1, 3))
			: PRIO_W'($urandom_range(0, 7));
		tail = 1'($urandom_range(0, 1));
		case (kind)
			0, 1, 2, 3: send_frame(tgt + $urandom_range(0, 12), ihl, prio, tail, FILL_RANDOM);
			4:          send_frame(tgt, ihl, prio, 1'b1, FILL_RANDOM);
			5:          send_frame($urandom_range(1, tgt - 1), ihl, prio, tail, FILL_RANDOM);
			6:          send_frame(MIN_FRAME_WORDS + $urandom_range(0, 4),
						4'($urandom_range(0, 4)), prio, tail, FILL_RANDOM);
			7:          send_frame($urandom_range(1, 40), ihl, prio, tail, FILL_NOISE);
			8:          send_frame(tgt + $urandom_range(0, 3), ihl, prio, tail, FILL_ONES);
			default:    send_frame(tgt + $urandom_range(0, 3), ihl, prio, tail, FILL_ZEROS);
		endcase
	endtask

	task automatic run_random(input int quota);
		int start;
		start = words_sent;
		while (words_sent - start < quota)
			random_frame();
	endtask

	// Drop valid, wait until every predicted word has come out, then let the
	// block idle before anything touches the registers.
	task automatic drain();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (open_words != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		burst_left = 0;
	endtask

	// Write all three DSCP registers back to back, valid held high throughout.
	task automatic program_dscp(input logic [DSCP_W-1:0] p1, input logic [DSCP_W-1:0] p2,
		input logic [DSCP_W-1:0] p3);
		cfg_idx_t          regs [3];
		logic [DSCP_W-1:0] vals [3];
		regs = '{CFG_DSCP_P1, CFG_DSCP_P2, CFG_DSCP_P3};
		vals = '{p1, p2, p3};
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.wdata <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		frame_ch.valid            <= 1'b0;
		frame_ch.frame_word       <= '0;
		frame_ch.frame_last       <= 1'b0;
		frame_ch.single_byte_tail <= 1'b0;
		frame_ch.packet_priority  <= '0;
		cfg_ch.valid              <= 1'b0;
		cfg_ch.index              <= CFG_DSCP_P1;
		cfg_ch.wdata              <= '0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, under the reset DSCP values: one-word frames at both data
		// extremes (one with a tail byte), then an all-ones header that forces
		// end-around carries, ending past the header on a one-byte tail.
		send_frame(1, 4'd0, 3'd0, 1'b0, FILL_ZEROS);
		send_frame(1, 4'd0, 3'd7, 1'b1, FILL_ONES);
		send_frame(MIN_FRAME_WORDS + 2, 4'd5, PRIO_THREE, 1'b1, FILL_ONES);
		run_random(55);
		drain();

		// Sweep the DSCP registers through both extremes and random settings.
		program_dscp('0, '0, '0);
		run_random(70);
		drain();
		program_dscp('1, '1, '1);
		run_random(70);
		drain();
		program_dscp(DSCP_W'($urandom_range(0, 63)), DSCP_W'($urandom_range(0, 63)),
			DSCP_W'($urandom_range(0, 63)));
		run_random(70);
		drain();
		program_dscp('1, '0, DSCP_W'($urandom_range(1, 62)));
		run_random(70);
		drain();
		program_dscp(DSCP_W'($urandom_range(0, 63)), DSCP_W'($urandom_range(0, 63)),
			DSCP_W'($urandom_range(0, 63)));
		run_random(70);
		drain();

		// Allow for a full-size header burst still in flight.
		repeat (100) @(posedge clk);
		$display("Sent %0d frames (%0d words) under %0d DSCP register settings.",
			frames_sent, words_sent, settings_used);
		$display("Checked %0d output words, incl. short, tail-ended and odd-IHL headers.",
			checked_words);
		if (remark_errors == 0 && open_words == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/dscprm_pkg.sv
hdl/dscprm_if.sv
hdl/dscprm_hdr_mem.sv
hdl/dscprm_csum.sv
hdl/dscp_remark_ip_checksum.sv
dv/dscprm_remark_check.sv
dv/tb.sv
